### rtl/wtm_pkg.sv
// Shared types, codes and constants for the wavetable tone mixer.
package wtm_pkg;

    // Request kinds carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_MIX   = 2'd2
    } action_t;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic REG_SAMPLE_RATE = 1'b0;
    localparam logic REG_ABS_MIX     = 1'b1;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 16;
    localparam int STEP_W   = 16;
    localparam int GAIN_W   = 15;
    localparam int SR_W     = 17;
    localparam int LEVEL_W  = 20;
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 3;

    // Serial arithmetic sizes
    localparam int PROD_W   = 34;   // product register (hi + lo)
    localparam int MUL_HI_W = 19;   // running upper part of the product
    localparam int DIV_W    = 32;   // dividend / quotient shift register
    localparam int REM_W    = 17;   // remainder and divisor
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] ADDR_DIV_BITS  = 5'd16;
    localparam logic [CNT_W-1:0] PHASE_DIV_BITS = 5'd17;
    localparam logic [CNT_W-1:0] MIX_DIV_BITS   = 5'd31;
    localparam logic [CNT_W-1:0] MUL_BITS       = 5'd15;

    // Arithmetic constants
    localparam logic [REM_W-1:0]   GAIN_SCALE   = 17'd10000;
    localparam logic [GAIN_W-1:0]  GAIN_CAP     = 15'd32000;
    localparam logic [20:0]        WEIGHT_MAX   = 21'd32767;
    localparam logic signed [PROD_W-1:0] SAMPLE_MAX = 34'sd32767;
    localparam logic signed [PROD_W-1:0] SAMPLE_MIN = -34'sd32768;
    localparam logic [LEVEL_W-1:0] LEVEL_SAT    = 20'hFFFFF;
    localparam logic [SR_W-1:0]    SR_RESET     = 17'd8000;
    localparam logic [SR_W-1:0]    SR_MAX       = 17'd65536;
    localparam logic [SR_W-1:0]    SR_MIN       = 17'd1;

    // Folds a small index into 0..n-1 by repeated subtraction.
    function automatic logic [2:0] wrap_index(input logic [2:0] v, input int unsigned n);
        logic [2:0] r;
        r = v;
        for (int i = 0; i < 7; i++) begin
            if (32'(r) >= n) begin
                r = r - 3'(n);
            end
        end
        return r;
    endfunction

endpackage

### rtl/wavetable_tone_mixer.sv
// Wavetable tone mixer: table store, phase counters, bit-serial multiply and divide.
// Table write, phase clear and unused requests complete on acceptance. A mix reads the
// table (folded first if the phase is past it) and advances the phase, folding on a wrap;
// a relative first channel or zero-weight blend stops there; others multiply and divide.
// One request at a time; a last channel also waits while the result register is full.
// rst_n clears phases, accumulator, level and clip flag, not the payload or the tables.
module wavetable_tone_mixer #(
    parameter int TABLE_DEPTH  = 65536,
    parameter int NUM_WAVES    = 4,
    parameter int NUM_CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // wave_select[1:0], table_addr[17:2], table_data[33:18], channel[36:34],
    // step[52:37], gain[67:53], zero[71:68]
    input  logic [wtm_pkg::S_DATA_W-1:0] s_tdata,
    // action[1:0], first_channel[2]
    input  logic [wtm_pkg::S_USER_W-1:0] s_tuser,
    input  logic        s_tlast,             // last_channel

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [wtm_pkg::SAMPLE_W-1:0] m_tdata, // mixed_sample[15:0]
    output logic        m_tuser               // clipped[0]
);

    localparam int MEM_DEPTH = NUM_WAVES * TABLE_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [wtm_pkg::REM_W-1:0] TABLE_LEN = wtm_pkg::REM_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR_DIV,     // phase mod table length
        S_READ,         // table read issued
        S_LOAD,         // sample ready, phase advance
        S_PHASE_DIV,    // (phase + step) mod sample rate
        S_SETUP,        // choose mixing path
        S_SCALE,        // halve level and gain until their sum fits 15 bits
        S_MUL,          // serial multiply-accumulate
        S_ABS,          // sign/magnitude split before divide
        S_MIX_DIV,      // serial divide by weight sum or gain scale
        S_FINISH,       // sign restore, add, clip
        S_DONE          // hand result to the output register
    } state_t;

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [wtm_pkg::SR_W-1:0]    sample_rate_reg, sample_rate_next;
    logic                        absolute_reg, absolute_next;
    logic [wtm_pkg::PHASE_W-1:0] phase_reg [NUM_CHANNELS];
    logic [wtm_pkg::PHASE_W-1:0] phase_next [NUM_CHANNELS];
    logic signed [wtm_pkg::SAMPLE_W-1:0] acc_reg, acc_next;
    logic [wtm_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                        clip_seen_reg, clip_seen_next;
    logic [wtm_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    // payload registers, no reset
    logic                        first_reg, first_next;
    logic                        last_reg, last_next;
    logic [CH_W-1:0]             ch_reg, ch_next;
    logic [1:0]                  wsel_reg, wsel_next;
    logic [wtm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [wtm_pkg::GAIN_W-1:0]  gain_reg, gain_next;
    logic [wtm_pkg::PHASE_W-1:0] ph_reg, ph_next;
    logic [MEM_AW-1:0]           rd_addr_reg, rd_addr_next;
    logic [wtm_pkg::LEVEL_W-1:0] l_reg, l_next;
    logic [wtm_pkg::GAIN_W-1:0]  g_reg, g_next;
    logic [wtm_pkg::GAIN_W-1:0]  ml_reg, ml_next;
    logic [wtm_pkg::GAIN_W-1:0]  mg_reg, mg_next;
    logic [wtm_pkg::MUL_HI_W-1:0] hi_reg, hi_next;
    logic [wtm_pkg::GAIN_W-1:0]  lo_reg, lo_next;
    logic [wtm_pkg::DIV_W-1:0]   dv_reg, dv_next;
    logic [wtm_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [wtm_pkg::REM_W-1:0]   dvs_reg, dvs_next;
    logic                        neg_reg, neg_next;
    logic [wtm_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                        out_clip_reg, out_clip_next;

    // table store
    logic signed [wtm_pkg::SAMPLE_W-1:0] wave_mem [MEM_DEPTH];
    logic signed [wtm_pkg::SAMPLE_W-1:0] rdata_reg;

    //------------------------------------------------------------------
    // Request fields
    //------------------------------------------------------------------
    logic                        s_accept;
    wtm_pkg::action_t            in_action;
    logic [1:0]                  in_wsel;
    logic [wtm_pkg::PHASE_W-1:0] in_addr;
    logic [wtm_pkg::SAMPLE_W-1:0] in_data;
    logic [CH_W-1:0]             in_ch;
    logic [wtm_pkg::PHASE_W-1:0] in_phase;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_action = wtm_pkg::action_t'(s_tuser[1:0]);
    assign in_wsel   = 2'(wtm_pkg::wrap_index({1'b0, s_tdata[1:0]}, NUM_WAVES));
    assign in_addr   = s_tdata[17:2];
    assign in_data   = s_tdata[33:18];
    assign in_ch     = CH_W'(wtm_pkg::wrap_index(s_tdata[36:34], NUM_CHANNELS));
    assign in_phase  = phase_reg[in_ch];

    // table write straight from the request
    logic              mem_wr;
    logic [MEM_AW-1:0] wr_addr;

    assign mem_wr  = s_accept && (in_action == wtm_pkg::ACT_WRITE)
                     && ({1'b0, in_addr} < TABLE_LEN);
    assign wr_addr = MEM_AW'(32'(in_wsel) * 32'(TABLE_DEPTH) + 32'(in_addr));

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            wtm_pkg::REG_SAMPLE_RATE: prdata = 32'(sample_rate_reg);
            wtm_pkg::REG_ABS_MIX:     prdata = 32'(absolute_reg);
            default:                  prdata = '0;
        endcase
    end

    // phase modulus: zero acts as one, anything above 65536 as 65536
    logic [wtm_pkg::SR_W-1:0] sr_eff;

    assign sr_eff = (sample_rate_reg == '0) ? wtm_pkg::SR_MIN :
                    (sample_rate_reg > wtm_pkg::SR_MAX) ? wtm_pkg::SR_MAX : sample_rate_reg;

    //------------------------------------------------------------------
    // Radix-2 restoring divider step, shared by all three folds.
    // Dividend enters left-aligned in dv_reg; quotient bits shift in at the bottom.
    //------------------------------------------------------------------
    logic [wtm_pkg::REM_W:0]     div_trial;
    logic                        div_ge;
    logic [wtm_pkg::REM_W-1:0]   div_rem;
    logic [wtm_pkg::DIV_W-1:0]   div_dv;

    assign div_trial = {rem_reg, dv_reg[wtm_pkg::DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, dvs_reg};
    assign div_rem   = div_ge ? wtm_pkg::REM_W'(div_trial - {1'b0, dvs_reg})
                              : div_trial[wtm_pkg::REM_W-1:0];
    assign div_dv    = {dv_reg[wtm_pkg::DIV_W-2:0], div_ge};

    //------------------------------------------------------------------
    // Serial multiply step: acc * l + wav * g, one multiplier bit of each per cycle,
    // partial sum shifted right into lo_reg.
    //------------------------------------------------------------------
    logic [wtm_pkg::MUL_HI_W-1:0] mul_a, mul_b, mul_sum;

    assign mul_a   = ml_reg[0] ? {{3{acc_reg[15]}}, acc_reg} : '0;
    assign mul_b   = mg_reg[0] ? {{3{rdata_reg[15]}}, rdata_reg} : '0;
    assign mul_sum = hi_reg + mul_a + mul_b;

    // product magnitude for the divider
    logic [wtm_pkg::PROD_W-1:0] prod, prod_mag;

    assign prod     = {hi_reg, lo_reg};
    assign prod_mag = hi_reg[wtm_pkg::MUL_HI_W-1] ? (~prod + 34'd1) : prod;

    // weight sum and level update
    logic [20:0] lg_sum, level_sum;

    assign lg_sum    = {1'b0, l_reg} + 21'(g_reg);
    assign level_sum = {1'b0, level_reg} + 21'(gain_reg);

    // phase advance
    logic [wtm_pkg::SR_W-1:0] phase_sum;

    assign phase_sum = {1'b0, ph_reg} + {1'b0, step_reg};

    // sign restore, optional accumulate, clip
    logic [wtm_pkg::PROD_W-1:0]        fin_mag;
    logic signed [wtm_pkg::PROD_W-1:0] fin_base, fin_total;
    logic                              fin_hi, fin_lo;

    assign fin_mag   = {2'b00, dv_reg};
    assign fin_base  = (absolute_reg && !first_reg) ? 34'(acc_reg) : '0;
    assign fin_total = fin_base + (neg_reg ? ~fin_mag : fin_mag) + 34'(neg_reg);
    assign fin_hi    = fin_total > wtm_pkg::SAMPLE_MAX;
    assign fin_lo    = fin_total < wtm_pkg::SAMPLE_MIN;

    //------------------------------------------------------------------
    // Next-state logic
    //------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        sample_rate_next = sample_rate_reg;
        absolute_next    = absolute_reg;
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        level_next       = level_reg;
        clip_seen_next   = clip_seen_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        ch_next          = ch_reg;
        wsel_next        = wsel_reg;
        step_next        = step_reg;
        gain_next        = gain_reg;
        ph_next          = ph_reg;
        rd_addr_next     = rd_addr_reg;
        l_next           = l_reg;
        g_next           = g_reg;
        ml_next          = ml_reg;
        mg_next          = mg_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        dv_next          = dv_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        neg_next         = neg_reg;
        out_sample_next  = out_sample_reg;
        out_clip_next    = out_clip_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            case (paddr[2])
                wtm_pkg::REG_SAMPLE_RATE: sample_rate_next = pwdata[wtm_pkg::SR_W-1:0];
                wtm_pkg::REG_ABS_MIX:     absolute_next    = pwdata[0];
                default:                  ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_action)
                        wtm_pkg::ACT_CLEAR:
                        begin
                            for (int i = 0; i < NUM_CHANNELS; i++)
                            begin
                                phase_next[i] = '0;
                            end
                        end
                        wtm_pkg::ACT_MIX:
                        begin
                            first_next = s_tuser[2];
                            last_next  = s_tlast;
                            ch_next    = in_ch;
                            wsel_next  = in_wsel;
                            step_next  = s_tdata[52:37];
                            gain_next  = s_tdata[67:53];
                            ph_next    = in_phase;
                            if ({1'b0, in_phase} < TABLE_LEN)
                            begin
                                rd_addr_next = MEM_AW'(32'(in_wsel) * 32'(TABLE_DEPTH)
                                                       + 32'(in_phase));
                                state_next   = S_READ;
                            end
                            else
                            begin
                                dv_next    = {in_phase, 16'h0000};
                                rem_next   = '0;
                                dvs_next   = TABLE_LEN;
                                cnt_next   = wtm_pkg::ADDR_DIV_BITS;
                                state_next = S_ADDR_DIV;
                            end
                        end
                        // table writes go straight to the store
                        default: ;
                    endcase
                end
            end

            S_ADDR_DIV:
            begin
                dv_next  = div_dv;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 5'd1)
                begin
                    rd_addr_next = MEM_AW'(32'(wsel_reg) * 32'(TABLE_DEPTH) + 32'(div_rem));
                    state_next   = S_READ;
                end
            end

            S_READ:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if (phase_sum < sr_eff)
                begin
                    phase_next[ch_reg] = phase_sum[wtm_pkg::PHASE_W-1:0];
                    state_next         = S_SETUP;
                end
                else
                begin
                    dv_next    = {phase_sum, 15'h0000};
                    rem_next   = '0;
                    dvs_next   = sr_eff;
                    cnt_next   = wtm_pkg::PHASE_DIV_BITS;
                    state_next = S_PHASE_DIV;
                end
            end

            S_PHASE_DIV:
            begin
                dv_next  = div_dv;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 5'd1)
                begin
                    phase_next[ch_reg] = div_rem[wtm_pkg::PHASE_W-1:0];
                    state_next         = S_SETUP;
                end
            end

            S_SETUP:
            begin
                if (first_reg)
                begin
                    clip_seen_next = 1'b0;
                end
                hi_next  = '0;
                lo_next  = '0;
                cnt_next = wtm_pkg::MUL_BITS;
                if (!absolute_reg)
                begin
                    if (first_reg)
                    begin
                        acc_next   = rdata_reg;
                        level_next = wtm_pkg::LEVEL_W'(gain_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        level_next = level_sum[20] ? wtm_pkg::LEVEL_SAT
                                                   : level_sum[wtm_pkg::LEVEL_W-1:0];
                        l_next     = level_reg;
                        g_next     = gain_reg;
                        state_next = S_SCALE;
                    end
                end
                else
                begin
                    ml_next  = '0;
                    dvs_next = wtm_pkg::GAIN_SCALE;
                    if (first_reg)
                    begin
                        level_next = '0;
                        mg_next    = (gain_reg > wtm_pkg::GAIN_CAP) ? wtm_pkg::GAIN_CAP
                                                                    : gain_reg;
                    end
                    else
                    begin
                        mg_next = gain_reg;
                    end
                    state_next = S_MUL;
                end
            end

            S_SCALE:
            begin
                if (lg_sum > wtm_pkg::WEIGHT_MAX)
                begin
                    l_next = l_reg >> 1;
                    g_next = g_reg >> 1;
                end
                else if (lg_sum == '0)
                begin
                    // zero weight: result is zero, no clip
                    acc_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ml_next    = l_reg[wtm_pkg::GAIN_W-1:0];
                    mg_next    = g_reg;
                    dvs_next   = wtm_pkg::REM_W'(lg_sum);
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                hi_next  = {mul_sum[wtm_pkg::MUL_HI_W-1], mul_sum[wtm_pkg::MUL_HI_W-1:1]};
                lo_next  = {mul_sum[0], lo_reg[wtm_pkg::GAIN_W-1:1]};
                ml_next  = ml_reg >> 1;
                mg_next  = mg_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = S_ABS;
                end
            end

            S_ABS:
            begin
                // magnitude stays below 2^31
                neg_next   = hi_reg[wtm_pkg::MUL_HI_W-1];
                dv_next    = {prod_mag[30:0], 1'b0};
                rem_next   = '0;
                cnt_next   = wtm_pkg::MIX_DIV_BITS;
                state_next = S_MIX_DIV;
            end

            S_MIX_DIV:
            begin
                dv_next  = div_dv;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (fin_hi)
                begin
                    acc_next       = 16'sh7FFF;
                    clip_seen_next = 1'b1;
                end
                else if (fin_lo)
                begin
                    acc_next       = -16'sh8000;
                    clip_seen_next = 1'b1;
                end
                else
                begin
                    acc_next = fin_total[wtm_pkg::SAMPLE_W-1:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = acc_reg;
                    out_clip_next   = clip_seen_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // Control and architectural state
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_rate_reg <= wtm_pkg::SR_RESET;
            absolute_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                phase_reg[i] <= '0;
            end
            acc_reg         <= '0;
            level_reg       <= '0;
            clip_seen_reg   <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sample_rate_reg <= sample_rate_next;
            absolute_reg    <= absolute_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            level_reg       <= level_next;
            clip_seen_reg   <= clip_seen_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        last_reg       <= last_next;
        ch_reg         <= ch_next;
        wsel_reg       <= wsel_next;
        step_reg       <= step_next;
        gain_reg       <= gain_next;
        ph_reg         <= ph_next;
        rd_addr_reg    <= rd_addr_next;
        l_reg          <= l_next;
        g_reg          <= g_next;
        ml_reg         <= ml_next;
        mg_reg         <= mg_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        dv_reg         <= dv_next;
        rem_reg        <= rem_next;
        dvs_reg        <= dvs_next;
        neg_reg        <= neg_next;
        out_sample_reg <= out_sample_next;
        out_clip_reg   <= out_clip_next;
    end

    // table store: one write port from the request, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            wave_mem[wr_addr] <= in_data;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= wave_mem[rd_addr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_clip_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    // remainder never reaches the divisor while a fold runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR_DIV || state_reg == S_PHASE_DIV || state_reg == S_MIX_DIV)
        |-> (rem_reg < dvs_reg))
    else $error("divider remainder out of range");

    // divisor for the mix is nonzero and fits 15 bits before the multiply starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (dvs_reg != '0 && dvs_reg <= 17'd32767))
    else $error("mix divisor out of range");

    // table read stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (32'(rd_addr_reg) < 32'(MEM_DEPTH)))
    else $error("table read address out of range");

    // a fresh result only follows a finished last-channel mix
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(state_reg == S_DONE && last_reg))
    else $error("result without a last-channel mix");

endmodule
